### hw/rtl/nss_pkg.sv
// Shared types and codes of the nearest sector request scheduler.
`timescale 1ns / 1ps
package nss_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SECTOR_BITS = 48;
  localparam int TAG_BITS    = 8;
  localparam int LEN_BITS    = 16;

  localparam logic [1:0] ST_QUEUED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_SENT   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Commands from the sequencer to one queue.
  typedef struct packed {
    logic ins;
    logic rd_head;
    logic pop;
  } nss_qcmd_t;

endpackage

### hw/rtl/nss_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module nss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/nss_queue.sv
// One sorted request queue: circular RAM, insertion walk from the tail.
`timescale 1ns / 1ps
module nss_queue
  import nss_pkg::*;
#(
  parameter int   DEPTH     = QUEUE_DEPTH,
  parameter int   SB        = SECTOR_BITS,
  parameter int   TB        = TAG_BITS,
  parameter logic ASCENDING = 1'b1,
  localparam int  AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int  CW = $clog2(DEPTH + 1),
  localparam int  W  = SB + LEN_BITS + TB
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nss_qcmd_t           cmd_i,
  input  logic [SB-1:0]       sector_i,
  input  logic [LEN_BITS-1:0] length_i,
  input  logic [TB-1:0]       tag_i,
  output logic [CW-1:0]       count_o,
  output logic                busy_o,
  output logic [SB-1:0]       head_sector_o,
  output logic [LEN_BITS-1:0] head_length_o,
  output logic [TB-1:0]       head_tag_o
);

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_RD   = 2'd1;
  localparam logic [1:0] Q_CMP  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] j_q, j_d;
  logic [W-1:0]  new_q, new_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;
  logic [CW-1:0] jm1;
  logic [SB-1:0] rd_sector;
  logic          move;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, b} + {1'b0, i};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign jm1       = j_q - CW'(1);
  assign rd_sector = rdata[SB-1:0];
  assign move      = ASCENDING ? (rd_sector > new_q[SB-1:0]) : (rd_sector < new_q[SB-1:0]);

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    count_d = count_q;
    j_d     = j_q;
    new_d   = new_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = base_q;
    raddr   = base_q;
    wdata   = new_q;
    case (state_q)
      Q_IDLE: begin
        if (cmd_i.rd_head) begin
          re = 1'b1;
        end
        if (cmd_i.ins) begin
          new_d   = {tag_i, length_i, sector_i};
          j_d     = count_q;
          state_d = Q_RD;
        end
        if (cmd_i.pop) begin
          base_d  = (base_q == AW'(DEPTH - 1)) ? '0 : base_q + AW'(1);
          count_d = count_q - CW'(1);
        end
      end
      Q_RD: begin
        if (j_q == '0) begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
          state_d = Q_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = phys(base_q, jm1);
          state_d = Q_CMP;
        end
      end
      Q_CMP: begin
        we    = 1'b1;
        waddr = phys(base_q, j_q);
        if (move) begin
          // shift the entry one place toward the tail
          wdata   = rdata;
          j_d     = jm1;
          state_d = Q_RD;
        end else begin
          count_d = count_q + CW'(1);
          state_d = Q_IDLE;
        end
      end
      default: state_d = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      base_q  <= '0;
      count_q <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      count_q <= count_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

  nss_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign count_o       = count_q;
  assign busy_o        = (state_q != Q_IDLE);
  assign head_sector_o = rdata[SB-1:0];
  assign head_length_o = rdata[SB+LEN_BITS-1:SB];
  assign head_tag_o    = rdata[W-1:SB+LEN_BITS];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count overflow");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins && state_q == Q_IDLE) |-> count_q < CW'(DEPTH))
    else $error("insert into full queue");
  a_cmp_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == Q_CMP |-> j_q != '0) else $error("walk compare at slot zero");

endmodule

### hw/rtl/nearest_sector_request_scheduler_unit.sv
// Top level of the nearest sector request scheduler.
// Path from the accepting edge to the result register: full queue or nothing to dispatch
//   goes straight to the response state, dispatch through the head read, add through the insertion walk.
// Flow: one item at a time, the next can be taken in the cycle after the result loads; the
//   insertion walk, one step per shifted entry, sets the add rate; a stalled result waits.
// Reset clears the counts, queue bases, head position and output valid; RAM contents stay.
`timescale 1ns / 1ps
module nearest_sector_request_scheduler_unit
  import nss_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH,
  parameter int SECTOR_BITS_P = SECTOR_BITS,
  parameter int TAG_BITS_P    = TAG_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [SECTOR_BITS_P-1:0] request_sector_i,
  input  logic [LEN_BITS-1:0]      request_length_i,
  input  logic [TAG_BITS_P-1:0]    request_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [TAG_BITS_P-1:0]    out_tag_o,
  output logic [SECTOR_BITS_P-1:0] out_sector_o,
  output logic [LEN_BITS-1:0]      out_length_o
);

  localparam int SB = SECTOR_BITS_P;
  localparam int TB = TAG_BITS_P;
  localparam int CW = $clog2(QUEUE_DEPTH_P + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_HRD  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [1:0]    res_q, res_d;
  logic          sel_lo_q, sel_lo_d;
  logic          ins_lo_q, ins_lo_d;
  logic [SB-1:0] pos_q, pos_d;

  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [TB-1:0]       out_tag_q;
  logic [SB-1:0]       out_sector_q;
  logic [LEN_BITS-1:0] out_length_q;

  nss_qcmd_t           cmd_up, cmd_lo;
  logic [CW-1:0]       cnt_up, cnt_lo;
  logic                busy_up, busy_lo;
  logic [SB-1:0]       hs_up, hs_lo;
  logic [LEN_BITS-1:0] hl_up, hl_lo;
  logic [TB-1:0]       ht_up, ht_lo;

  logic                accept, out_free, go_lower, lower_near;
  logic [SB-1:0]       sel_sector;
  logic [LEN_BITS-1:0] sel_length;
  logic [TB-1:0]       sel_tag;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign go_lower = pos_q > request_sector_i;

  // Lower head wins exactly when up + lo > 2 * pos, on one extra bit.
  assign lower_near = ({1'b0, hs_up} + {1'b0, hs_lo}) > {pos_q, 1'b0};

  assign sel_sector = sel_lo_q ? hs_lo : hs_up;
  assign sel_length = sel_lo_q ? hl_lo : hl_up;
  assign sel_tag    = sel_lo_q ? ht_lo : ht_up;

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    sel_lo_d = sel_lo_q;
    ins_lo_d = ins_lo_q;
    pos_d    = pos_q;
    cmd_up   = '0;
    cmd_lo   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            // Add: pick the queue by the head position; a full queue rejects.
            ins_lo_d = go_lower;
            if ((go_lower ? cnt_lo : cnt_up) == CW'(QUEUE_DEPTH_P)) begin
              res_d   = ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_up.ins = !go_lower;
              cmd_lo.ins = go_lower;
              state_d    = S_INS;
            end
          end else if (cnt_up == '0 && cnt_lo == '0) begin
            res_d   = ST_EMPTY;
            state_d = S_RESP;
          end else begin
            // Fetch both heads; the RAM output holds them until the pop.
            cmd_up.rd_head = 1'b1;
            cmd_lo.rd_head = 1'b1;
            state_d        = S_HRD;
          end
        end
      end
      S_INS: begin
        if (!(ins_lo_q ? busy_lo : busy_up)) begin
          res_d   = ST_QUEUED;
          state_d = S_RESP;
        end
      end
      S_HRD: begin
        // Ties go to the upper queue.
        sel_lo_d = (cnt_up == '0) || ((cnt_lo != '0) && lower_near);
        res_d    = ST_SENT;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          if (res_q == ST_SENT) begin
            cmd_up.pop = !sel_lo_q;
            cmd_lo.pop = sel_lo_q;
            pos_d      = sel_sector + SB'(sel_length);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register on the transfer out of the response state.
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    sel_lo_q <= sel_lo_d;
    ins_lo_q <= ins_lo_d;
    if (state_q == S_RESP && out_free) begin
      out_status_q <= res_q;
      if (res_q == ST_SENT) begin
        out_tag_q    <= sel_tag;
        out_sector_q <= sel_sector;
        out_length_q <= sel_length;
      end else begin
        out_tag_q    <= '0;
        out_sector_q <= '0;
        out_length_q <= '0;
      end
    end
  end

  nss_queue #(.DEPTH(QUEUE_DEPTH_P), .SB(SB), .TB(TB), .ASCENDING(1'b1)) u_upper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_up),
    .sector_i      (request_sector_i),
    .length_i      (request_length_i),
    .tag_i         (request_tag_i),
    .count_o       (cnt_up),
    .busy_o        (busy_up),
    .head_sector_o (hs_up),
    .head_length_o (hl_up),
    .head_tag_o    (ht_up)
  );

  nss_queue #(.DEPTH(QUEUE_DEPTH_P), .SB(SB), .TB(TB), .ASCENDING(1'b0)) u_lower (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_lo),
    .sector_i      (request_sector_i),
    .length_i      (request_length_i),
    .tag_i         (request_tag_i),
    .count_o       (cnt_lo),
    .busy_o        (busy_lo),
    .head_sector_o (hs_lo),
    .head_length_o (hl_lo),
    .head_tag_o    (ht_lo)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_tag_o    = out_tag_q;
  assign out_sector_o = out_sector_q;
  assign out_length_o = out_length_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("accepted item left no work");
  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_up.pop && cmd_lo.pop)) else $error("both queues popped");
  a_hrd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HRD |-> (cnt_up != '0 || cnt_lo != '0))
    else $error("dispatch compare with both queues empty");

endmodule
